// ----- hdl/assert_macros.svh -----
// Assertion macros used by the compensation block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ESHC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ESHC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/eshc_pkg.sv -----
// Types, register map and constants of the environmental compensation block.
package eshc_pkg;

  localparam int unsigned CfgAddrW = 5;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_CAL_T1       = 3'd0;
  localparam reg_idx_t REG_CAL_T2       = 3'd1;
  localparam reg_idx_t REG_CAL_T3       = 3'd2;
  localparam reg_idx_t REG_CAL_H2       = 3'd3;
  localparam reg_idx_t REG_CAL_H4       = 3'd4;
  localparam reg_idx_t REG_CAL_H5       = 3'd5;
  localparam reg_idx_t REG_CAL_H_SMALL  = 3'd6;
  localparam reg_idx_t REG_TEMP_OFFSET  = 3'd7;

  localparam logic CMD_TEMP = 1'b0;
  localparam logic CMD_HUM  = 1'b1;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] h2;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [23:0] h_small;
    logic [14:0] temp_offset;
  } cfg_t;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  localparam logic [31:0] TEMP_SCALE   = 32'd5;
  localparam logic [31:0] TEMP_ROUND   = 32'd128;
  // trunc(y*256/5) = 51*y + floor(y/5); floor(y/5) = (y*26215) >> 17 for y < 2^15
  localparam logic [31:0] DIV5_WHOLE   = 32'd51;
  localparam logic [31:0] DIV5_RECIP   = 32'd26215;
  localparam int unsigned DIV5_SHIFT   = 17;

  localparam logic [31:0] HUM_T_OFFSET = 32'd76800;
  localparam logic [31:0] HUM_ROUND_P  = 32'd16384;
  localparam logic [31:0] HUM_Q_OFFSET = 32'd32768;
  localparam logic [31:0] HUM_G_OFFSET = 32'd2097152;
  localparam logic [31:0] HUM_ROUND_G  = 32'd8192;
  localparam logic [31:0] HUM_CLAMP    = 32'd419430400;
  localparam logic [31:0] HUM_OUT_MAX  = 32'd102400;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    return $unsigned($signed(v) >>> n);
  endfunction

endpackage

// ----- hdl/eshc_in_if.sv -----
// Sample channel: valid/ready handshake carrying one raw sample.
interface eshc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [19:0] raw_sample;

  modport source (output valid, output cmd, output raw_sample, input ready);
  modport sink   (input valid, input cmd, input raw_sample, output ready);
endinterface

// ----- hdl/eshc_out_if.sv -----
// Result channel: valid/ready handshake carrying one compensated value.
interface eshc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] result_value;

  modport source (output valid, output result_kind, output result_value, input ready);
  modport sink   (input valid, input result_kind, input result_value, output ready);
endinterface

// ----- hdl/eshc_mul.sv -----
// Shared 32x32 multiplier, low word of the product registered.
module eshc_mul (
  input  logic              clk_i,
  input  eshc_pkg::mul_req_t req_i,
  output logic [31:0]       prod_o
);
  import eshc_pkg::*;

  logic [31:0] prod_q;

  // low 32 bits only, two's-complement wrap
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- hdl/eshc_regs.sv -----
// APB-style calibration register file.
module eshc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eshc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output eshc_pkg::cfg_t                cfg_o
);
  import eshc_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[CfgAddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_CAL_T1:      cfg_d.t1          = pwdata[15:0];
        REG_CAL_T2:      cfg_d.t2          = pwdata[15:0];
        REG_CAL_T3:      cfg_d.t3          = pwdata[15:0];
        REG_CAL_H2:      cfg_d.h2          = pwdata[15:0];
        REG_CAL_H4:      cfg_d.h4          = pwdata[15:0];
        REG_CAL_H5:      cfg_d.h5          = pwdata[15:0];
        REG_CAL_H_SMALL: cfg_d.h_small     = pwdata[23:0];
        REG_TEMP_OFFSET: cfg_d.temp_offset = pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAL_T1:      prdata = {16'd0, cfg_q.t1};
      REG_CAL_T2:      prdata = {16'd0, cfg_q.t2};
      REG_CAL_T3:      prdata = {16'd0, cfg_q.t3};
      REG_CAL_H2:      prdata = {16'd0, cfg_q.h2};
      REG_CAL_H4:      prdata = {16'd0, cfg_q.h4};
      REG_CAL_H5:      prdata = {16'd0, cfg_q.h5};
      REG_CAL_H_SMALL: prdata = {8'd0, cfg_q.h_small};
      REG_TEMP_OFFSET: prdata = {17'd0, cfg_q.temp_offset};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/eshc_core.sv -----
// Compensation sequencer: drives the shared multiplier step by step.
`include "assert_macros.svh"

module eshc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           cmd_i,
  input  logic [19:0]    raw_i,
  input  eshc_pkg::cfg_t cfg_i,
  input  logic           slot_free_i,
  output logic           idle_o,
  output logic           done_o,
  output logic           kind_o,
  output logic [31:0]    value_o
);
  import eshc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8,
    S_OUT
  } state_e;

  state_e      state_q, state_d;
  logic        cmd_q, cmd_d;
  logic [19:0] raw_q, raw_d;
  logic [31:0] x_q, x_d;
  logic [31:0] y_q, y_d;
  logic [31:0] z_q, z_d;
  logic [31:0] fine_q, fine_d;

  mul_req_t    mul_req;
  logic [31:0] p;

  logic        off_neg;
  logic [14:0] off_mag;
  logic [31:0] t_diff;
  logic [31:0] div_sum;
  logic [31:0] hum_clamped;

  eshc_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (p)
  );

  assign off_neg = cfg_i.temp_offset[14];
  assign off_mag = off_neg ? 15'(~cfg_i.temp_offset + 15'd1) : cfg_i.temp_offset;
  assign t_diff  = {16'd0, raw_q[19:4]} - {16'd0, cfg_i.t1};
  assign div_sum = y_q + p;

  always_comb begin
    if (x_q[31]) begin
      hum_clamped = '0;
    end else if (x_q > HUM_CLAMP) begin
      hum_clamped = HUM_CLAMP;
    end else begin
      hum_clamped = x_q;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    raw_d   = raw_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    fine_d  = fine_q;
    mul_req = '0;
    done_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          raw_d   = raw_i;
          state_d = (cmd_i == CMD_HUM) ? S_H0 : S_T0;
        end
      end
      // temperature
      S_T0: begin
        mul_req = '{en: 1'b1,
                    a: {15'd0, raw_q[19:3]} - {15'd0, cfg_i.t1, 1'b0},
                    b: sext16(cfg_i.t2)};
        state_d = S_T1;
      end
      S_T1: begin
        x_d     = asr(p, 5'd11);
        mul_req = '{en: 1'b1, a: t_diff, b: t_diff};
        state_d = S_T2;
      end
      S_T2: begin
        mul_req = '{en: 1'b1, a: asr(p, 5'd12), b: sext16(cfg_i.t3)};
        state_d = S_T3;
      end
      S_T3: begin
        x_d     = x_q + asr(p, 5'd14);
        mul_req = '{en: 1'b1, a: {17'd0, off_mag}, b: DIV5_RECIP};
        state_d = S_T4;
      end
      S_T4: begin
        y_d     = p >> DIV5_SHIFT;
        mul_req = '{en: 1'b1, a: {17'd0, off_mag}, b: DIV5_WHOLE};
        state_d = S_T5;
      end
      S_T5: begin
        y_d     = off_neg ? (~div_sum + 32'd1) : div_sum;
        state_d = S_T6;
      end
      S_T6: begin
        fine_d  = x_q + y_q;
        mul_req = '{en: 1'b1, a: x_q + y_q, b: TEMP_SCALE};
        state_d = S_T7;
      end
      S_T7: begin
        x_d     = asr(p + TEMP_ROUND, 5'd8);
        state_d = S_OUT;
      end
      // humidity
      S_H0: begin
        y_d     = fine_q - HUM_T_OFFSET;
        x_d     = ({16'd0, raw_q[15:0]} << 14) + HUM_ROUND_P - (sext16(cfg_i.h4) << 20);
        mul_req = '{en: 1'b1, a: fine_q - HUM_T_OFFSET, b: sext16(cfg_i.h5)};
        state_d = S_H1;
      end
      S_H1: begin
        x_d     = asr(x_q - p, 5'd15);
        mul_req = '{en: 1'b1, a: y_q, b: sext8(cfg_i.h_small[23:16])};
        state_d = S_H2;
      end
      S_H2: begin
        z_d     = asr(p, 5'd10);
        mul_req = '{en: 1'b1, a: y_q, b: {24'd0, cfg_i.h_small[15:8]}};
        state_d = S_H3;
      end
      S_H3: begin
        mul_req = '{en: 1'b1, a: z_q, b: asr(p, 5'd11) + HUM_Q_OFFSET};
        state_d = S_H4;
      end
      S_H4: begin
        mul_req = '{en: 1'b1, a: asr(p, 5'd10) + HUM_G_OFFSET, b: sext16(cfg_i.h2)};
        state_d = S_H5;
      end
      S_H5: begin
        mul_req = '{en: 1'b1, a: x_q, b: asr(p + HUM_ROUND_G, 5'd14)};
        state_d = S_H6;
      end
      S_H6: begin
        x_d     = p;
        mul_req = '{en: 1'b1, a: asr(p, 5'd15), b: asr(p, 5'd15)};
        state_d = S_H7;
      end
      S_H7: begin
        mul_req = '{en: 1'b1, a: asr(p, 5'd7), b: {24'd0, cfg_i.h_small[7:0]}};
        state_d = S_H8;
      end
      S_H8: begin
        x_d     = x_q - asr(p, 5'd4);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (slot_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_TEMP;
      raw_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      fine_q  <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      raw_q   <= raw_d;
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      fine_q  <= fine_d;
    end
  end

  assign idle_o  = (state_q == S_IDLE);
  assign kind_o  = cmd_q;
  assign value_o = (cmd_q == CMD_HUM) ? {12'd0, hum_clamped[31:12]} : x_q;

  `ESHC_ASSERT_IMP(a_start_when_idle, start_i, idle_o, "start while busy")
  `ESHC_ASSERT_NXT(a_start_leaves_idle, start_i, state_q != S_IDLE, "start ignored")
  `ESHC_ASSERT_IMP(a_done_needs_slot, done_o, slot_free_i, "result dropped")
  `ESHC_ASSERT_NXT(a_fine_only_t6, state_q != S_T6, $stable(fine_q), "fine temp changed")
  `ESHC_ASSERT_IMP(a_hum_range, done_o && (cmd_q == CMD_HUM), value_o <= HUM_OUT_MAX,
                   "humidity out of range")

endmodule

// ----- hdl/env_sensor_temp_humidity_compensation.sv -----
// Top level of the temperature and humidity compensation block.
// Each sample transaction (cmd 0 = 20-bit temperature, cmd 1 = humidity in the
// low 16 bits) yields exactly one result transaction tagged with the same kind.
// Temperature updates the stored fine temperature (calibration words t1..t3
// plus the user offset, offset*256/5 truncated toward zero) and returns it in
// 0.01 degC; humidity uses the stored fine temperature (0 after reset) and
// returns %RH * 1024, clamped to 0..102400. All math wraps at 32 bits.
// Rate: one sample at a time; a new sample is accepted only when the
// sequencer is idle again, after it has passed its result to the output
// register. The temperature and humidity sequences are paced by a single
// shared 32x32 multiplier producing one registered product per cycle for
// a chain of dependent products. The result sits in an output register, so the
// next sample can be accepted while the previous result waits to be taken.
// Calibration registers sit at byte address 4*index and should be written only
// while no transaction is in flight.
module env_sensor_temp_humidity_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  eshc_in_if.sink                       sample_i,
  eshc_out_if.source                    result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eshc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import eshc_pkg::*;

  cfg_t        cfg;
  logic        core_idle;
  logic        core_done;
  logic        core_kind;
  logic [31:0] core_value;
  logic        start;
  logic        slot_free;

  // output holding register
  logic        out_valid_q;
  logic        out_kind_q;
  logic [31:0] out_value_q;

  eshc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sample accepted only while the sequencer is idle
  assign sample_i.ready = core_idle;
  assign start          = sample_i.valid & core_idle;

  // result slot is free when empty or being drained this cycle
  assign slot_free = ~out_valid_q | result_o.ready;

  eshc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (sample_i.cmd),
    .raw_i       (sample_i.raw_sample),
    .cfg_i       (cfg),
    .slot_free_i (slot_free),
    .idle_o      (core_idle),
    .done_o      (core_done),
    .kind_o      (core_kind),
    .value_o     (core_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_kind_q  <= core_kind;
      out_value_q <= core_value;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.result_kind  = out_kind_q;
  assign result_o.result_value = out_value_q;

endmodule
